// File: src/matrix_multiply_engine_defines.svh
// assertion macros for the matrix multiply engine
`ifndef MATRIX_MULTIPLY_ENGINE_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define MME_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mme assertion failed");
`define MME_ASSERT_NORST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("mme assertion failed");
`else
`define MME_ASSERT(lbl, clk, rst, prop)
`define MME_ASSERT_NORST(lbl, clk, prop)
`endif

`endif

// File: src/mme_pkg.sv
// shared types, constants and helpers of the matrix multiply engine
package mme_pkg;

   localparam int MAX_DIM_DEF = 8;
   localparam int ELEM_W      = 16;
   localparam int ACC_W       = 32;
   localparam int IDX_W       = 3;
   localparam int DIM_W       = 4;
   localparam int ADDR_W      = 2 * IDX_W;
   localparam int CSR_IDX_W   = 2;

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

   typedef enum logic [1:0] {
      KIND_LOAD_A = 2'd0,
      KIND_LOAD_B = 2'd1,
      KIND_START  = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_A    = 2'd0,
      CSR_INNER_DIM = 2'd1,
      CSR_COLS_B    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic             first;
      logic             last_k;
      logic             last;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } tag_type;

   typedef struct packed {
      logic              issue;
      tag_type           tag;
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
      logic              wr_left;
      logic              wr_right;
      logic [ADDR_W-1:0] wr_addr;
   } cmd_type;

   typedef struct packed {
      logic pipe_active;
   } status_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// File: src/matrix_multiply_engine.sv
// Load beats are taken one per cycle while idle and write one in-range element each.
// A start beat raises busy until every product term is issued and the pipeline drains; one
// multiply-accumulate per cycle through a three stage memory read, multiply, accumulate path.
// Each product element strobes once, in row-major order, with its row and column.
// Synchronous active high reset sets all shapes to 8; element stores are not cleared.
module matrix_multiply_engine #(
   parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_kind,
   input  logic [mme_pkg::IDX_W-1:0]         req_elem_row,
   input  logic [mme_pkg::IDX_W-1:0]         req_elem_col,
   input  logic signed [mme_pkg::ELEM_W-1:0] req_elem_value,
   output logic                              rsp_strobe,
   output logic signed [mme_pkg::ACC_W-1:0]  rsp_prod_value,
   output logic [mme_pkg::IDX_W-1:0]         rsp_prod_row,
   output logic [mme_pkg::IDX_W-1:0]         rsp_prod_col,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mme_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mme_pkg::DIM_W-1:0]         csr_data
);

   mme_pkg::cmd_type    cmd;
   mme_pkg::status_type status;

   mme_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_kind     (req_kind),
      .req_elem_row (req_elem_row),
      .req_elem_col (req_elem_col),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .status       (status)
   );

   mme_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_elem_value (req_elem_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_prod_value (rsp_prod_value),
      .rsp_prod_row   (rsp_prod_row),
      .rsp_prod_col   (rsp_prod_col),
      .rsp_last       (rsp_last)
   );

endmodule

// File: src/mme_ctrl.sv
// controller: shape registers, load decode and the row, column, inner sequencer
`include "matrix_multiply_engine_defines.svh"
module mme_ctrl #(
   parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_kind,
   input  logic [mme_pkg::IDX_W-1:0]      req_elem_row,
   input  logic [mme_pkg::IDX_W-1:0]      req_elem_col,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mme_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mme_pkg::DIM_W-1:0]      csr_data,
   output mme_pkg::cmd_type               cmd,
   input  mme_pkg::status_type            status
);

   localparam logic [mme_pkg::DIM_W-1:0] DIM_MAX = mme_pkg::DIM_W'(MAX_DIM);

   mme_pkg::state_type state_ff, state_in;

   logic [mme_pkg::DIM_W-1:0] rows_ff, inner_ff, cols_ff;
   logic [mme_pkg::DIM_W-1:0] nr_ff, nr_in, nk_ff, nk_in, nc_ff, nc_in;
   logic [mme_pkg::IDX_W-1:0] r_ff, r_in, c_ff, c_in, k_ff, k_in;

   logic accept, go, in_range, last_k, last_c, last_r;
   mme_pkg::kind_type kind;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != mme_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign kind      = mme_pkg::kind_type'(req_kind);
   assign in_range  = ({1'b0, req_elem_row} < DIM_MAX) && ({1'b0, req_elem_col} < DIM_MAX);
   assign go        = accept && (kind == mme_pkg::KIND_START);

   assign last_k = (k_ff == mme_pkg::IDX_W'(nk_ff - mme_pkg::DIM_W'(1)));
   assign last_c = (c_ff == mme_pkg::IDX_W'(nc_ff - mme_pkg::DIM_W'(1)));
   assign last_r = (r_ff == mme_pkg::IDX_W'(nr_ff - mme_pkg::DIM_W'(1)));

   // shape registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= mme_pkg::DIM_RESET;
         inner_ff <= mme_pkg::DIM_RESET;
         cols_ff  <= mme_pkg::DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (mme_pkg::csr_index_type'(csr_index))
            mme_pkg::CSR_ROWS_A:    rows_ff  <= csr_data;
            mme_pkg::CSR_INNER_DIM: inner_ff <= csr_data;
            mme_pkg::CSR_COLS_B:    cols_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mme_pkg::ST_IDLE;
         r_ff     <= '0;
         c_ff     <= '0;
         k_ff     <= '0;
         nr_ff    <= mme_pkg::DIM_W'(1);
         nk_ff    <= mme_pkg::DIM_W'(1);
         nc_ff    <= mme_pkg::DIM_W'(1);
      end else begin
         state_ff <= state_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         k_ff     <= k_in;
         nr_ff    <= nr_in;
         nk_ff    <= nk_in;
         nc_ff    <= nc_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mme_pkg::ST_IDLE: begin
            if (go) state_in = mme_pkg::ST_RUN;
         end
         mme_pkg::ST_RUN: begin
            if (last_k && last_c && last_r) state_in = mme_pkg::ST_DRAIN;
         end
         mme_pkg::ST_DRAIN: begin
            if (!status.pipe_active) state_in = mme_pkg::ST_IDLE;
         end
         default: state_in = mme_pkg::ST_IDLE;
      endcase
   end

   // outputs and counters
   always_comb begin
      cmd          = '0;
      r_in         = r_ff;
      c_in         = c_ff;
      k_in         = k_ff;
      nr_in        = nr_ff;
      nk_in        = nk_ff;
      nc_in        = nc_ff;
      cmd.wr_addr  = mme_pkg::ADDR_W'(req_elem_row) * mme_pkg::ADDR_W'(MAX_DIM)
                   + mme_pkg::ADDR_W'(req_elem_col);
      cmd.addr_a   = mme_pkg::ADDR_W'(r_ff) * mme_pkg::ADDR_W'(MAX_DIM)
                   + mme_pkg::ADDR_W'(k_ff);
      cmd.addr_b   = mme_pkg::ADDR_W'(k_ff) * mme_pkg::ADDR_W'(MAX_DIM)
                   + mme_pkg::ADDR_W'(c_ff);
      cmd.tag.row  = r_ff;
      cmd.tag.col  = c_ff;
      cmd.tag.first  = (k_ff == '0);
      cmd.tag.last_k = last_k;
      cmd.tag.last   = last_k && last_c && last_r;
      unique case (state_ff)
         mme_pkg::ST_IDLE: begin
            cmd.wr_left  = accept && (kind == mme_pkg::KIND_LOAD_A) && in_range;
            cmd.wr_right = accept && (kind == mme_pkg::KIND_LOAD_B) && in_range;
            if (go) begin
               r_in  = '0;
               c_in  = '0;
               k_in  = '0;
               nr_in = mme_pkg::clamp_dim(rows_ff, DIM_MAX);
               nk_in = mme_pkg::clamp_dim(inner_ff, DIM_MAX);
               nc_in = mme_pkg::clamp_dim(cols_ff, DIM_MAX);
            end
         end
         mme_pkg::ST_RUN: begin
            cmd.issue = 1'b1;
            if (!last_k) begin
               k_in = k_ff + mme_pkg::IDX_W'(1);
            end else begin
               k_in = '0;
               if (!last_c) begin
                  c_in = c_ff + mme_pkg::IDX_W'(1);
               end else begin
                  c_in = '0;
                  r_in = r_ff + mme_pkg::IDX_W'(1);
               end
            end
         end
         mme_pkg::ST_DRAIN: ;
         default: ;
      endcase
   end

   `MME_ASSERT(a_idle_pipe_empty, clock, reset, (state_ff == mme_pkg::ST_IDLE) |-> !status.pipe_active)
   `MME_ASSERT(a_start_runs, clock, reset, go |=> (state_ff == mme_pkg::ST_RUN))
   `MME_ASSERT(a_last_drains, clock, reset, (cmd.issue && cmd.tag.last) |=> (state_ff == mme_pkg::ST_DRAIN))

endmodule

// File: src/mme_datapath.sv
// datapath: element memories, multiplier and saturating accumulator
`include "matrix_multiply_engine_defines.svh"
module mme_datapath #(
   parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mme_pkg::cmd_type                  cmd,
   output mme_pkg::status_type               status,
   input  logic signed [mme_pkg::ELEM_W-1:0] req_elem_value,
   output logic                              rsp_strobe,
   output logic signed [mme_pkg::ACC_W-1:0]  rsp_prod_value,
   output logic [mme_pkg::IDX_W-1:0]         rsp_prod_row,
   output logic [mme_pkg::IDX_W-1:0]         rsp_prod_col,
   output logic                              rsp_last
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [mme_pkg::ELEM_W-1:0] left_mem  [DEPTH];
   logic [mme_pkg::ELEM_W-1:0] right_mem [DEPTH];

   logic signed [mme_pkg::ELEM_W-1:0] a_rd_ff, b_rd_ff;
   logic signed [mme_pkg::ACC_W-1:0]  prod_ff, prod_in, acc_ff, acc_in;
   logic signed [mme_pkg::ACC_W:0]    sum;
   logic                              s1_valid_ff, s2_valid_ff, strobe_ff;
   mme_pkg::tag_type                  s1_tag_ff, s2_tag_ff, out_tag_ff;

   // memories
   always_ff @(posedge clock) begin
      if (cmd.wr_left) left_mem[cmd.wr_addr[AW-1:0]] <= req_elem_value;
      if (cmd.wr_right) right_mem[cmd.wr_addr[AW-1:0]] <= req_elem_value;
      a_rd_ff <= left_mem[cmd.addr_a[AW-1:0]];
      b_rd_ff <= right_mem[cmd.addr_b[AW-1:0]];
   end

   assign prod_in = a_rd_ff * b_rd_ff;

   // saturating accumulate
   always_comb begin
      if (s2_tag_ff.first) begin
         sum = {prod_ff[mme_pkg::ACC_W-1], prod_ff};
      end else begin
         sum = {prod_ff[mme_pkg::ACC_W-1], prod_ff} + {acc_ff[mme_pkg::ACC_W-1], acc_ff};
      end
      if (sum[mme_pkg::ACC_W] != sum[mme_pkg::ACC_W-1]) begin
         acc_in = sum[mme_pkg::ACC_W] ? {1'b1, {(mme_pkg::ACC_W-1){1'b0}}}
                                      : {1'b0, {(mme_pkg::ACC_W-1){1'b1}}};
      end else begin
         acc_in = sum[mme_pkg::ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
         strobe_ff   <= s2_valid_ff && s2_tag_ff.last_k;
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff <= cmd.tag;
      s2_tag_ff <= s1_tag_ff;
      prod_ff   <= prod_in;
      if (s2_valid_ff) begin
         acc_ff     <= acc_in;
         out_tag_ff <= s2_tag_ff;
      end
   end

   assign status.pipe_active = s1_valid_ff || s2_valid_ff;
   assign rsp_strobe         = strobe_ff;
   assign rsp_prod_value     = acc_ff;
   assign rsp_prod_row       = out_tag_ff.row;
   assign rsp_prod_col       = out_tag_ff.col;
   assign rsp_last           = out_tag_ff.last;

   `MME_ASSERT(a_last_ends_beats, clock, reset, (rsp_strobe && rsp_last) |=> !rsp_strobe)
   `MME_ASSERT(a_one_store_write, clock, reset, !(cmd.wr_left && cmd.wr_right))
   `MME_ASSERT(a_no_load_while_run, clock, reset, cmd.issue |-> !(cmd.wr_left || cmd.wr_right))

endmodule

// File: dv/matrix_multiply_engine_tb.sv
// testbench for the matrix multiply engine: directed and random beats checked by a predictor
`timescale 1ns / 1ps

module matrix_multiply_engine_tb;

   localparam int          ITEM_TARGET = 210;
   localparam int          SETTLE      = 16;
   localparam int          STALL_LIMIT = 1000;
   localparam int          PLAN_LEN    = 31;
   localparam int          STORE_DEPTH = mme_pkg::MAX_DIM_DEF * mme_pkg::MAX_DIM_DEF;
   localparam logic [1:0]  KIND_SPARE  = 2'd3;
   localparam logic        ACT_BEAT    = 1'b0;
   localparam logic        ACT_REG     = 1'b1;

   typedef struct packed {
      logic                        act;
      logic [1:0]                  code;
      logic [mme_pkg::IDX_W-1:0]   row;
      logic [mme_pkg::IDX_W-1:0]   col;
      logic [mme_pkg::ELEM_W-1:0]  value;
      logic                        chk;
      logic [mme_pkg::ACC_W-1:0]   want;
   } step_type;

   typedef struct packed {
      logic signed [mme_pkg::ACC_W-1:0] value;
      logic [mme_pkg::IDX_W-1:0]        row;
      logic [mme_pkg::IDX_W-1:0]        col;
      logic                             last;
   } cell_type;

   // value typed in only where it is plain; start rows without it go to the predictor
   localparam step_type PLAN [PLAN_LEN] = '{
      '{ACT_REG,  mme_pkg::CSR_ROWS_A,    3'd0, 3'd0, 16'h0001, 1'b0, 32'h0},
      '{ACT_REG,  mme_pkg::CSR_INNER_DIM, 3'd0, 3'd0, 16'h0001, 1'b0, 32'h0},
      '{ACT_REG,  mme_pkg::CSR_COLS_B,    3'd0, 3'd0, 16'h0001, 1'b0, 32'h0},
      '{ACT_BEAT, mme_pkg::KIND_LOAD_A,   3'd0, 3'd0, 16'h0100, 1'b0, 32'h0},
      '{ACT_BEAT, mme_pkg::KIND_LOAD_B,   3'd0, 3'd0, 16'h0100, 1'b0, 32'h0},
      '{ACT_BEAT, mme_pkg::KIND_START,    3'd0, 3'd0, 16'h0000, 1'b1, 32'h0001_0000},
      '{ACT_BEAT, mme_pkg::KIND_LOAD_A,   3'd0, 3'd0, 16'h8000, 1'b0, 32'h0},
      '{ACT_BEAT, mme_pkg::KIND_LOAD_B,   3'd0, 3'd0, 16'h8000, 1'b0, 32'h0},
      '{ACT_BEAT, mme_pkg::KIND_START,    3'd7, 3'd7, 16'hffff, 1'b1, 32'h4000_0000},
      '{ACT_BEAT, KIND_SPARE,             3'd7, 3'd7, 16'hffff, 1'b0, 32'h0},
      '{ACT_BEAT, mme_pkg::KIND_START,    3'd0, 3'd0, 16'h0000, 1'b1, 32'h4000_0000},
      '{ACT_BEAT, mme_pkg::KIND_LOAD_A,   3'd0, 3'd1, 16'h8000, 1'b0, 32'h0},
      '{ACT_BEAT, mme_pkg::KIND_LOAD_B,   3'd1, 3'd0, 16'h8000, 1'b0, 32'h0},
      '{ACT_REG,  mme_pkg::CSR_INNER_DIM, 3'd0, 3'd0, 16'h0002, 1'b0, 32'h0},
      '{ACT_BEAT, mme_pkg::KIND_START,    3'd0, 3'd0, 16'h0000, 1'b1, 32'h7fff_ffff},
      '{ACT_BEAT, mme_pkg::KIND_LOAD_B,   3'd0, 3'd0, 16'h7fff, 1'b0, 32'h0},
      '{ACT_BEAT, mme_pkg::KIND_LOAD_B,   3'd1, 3'd0, 16'h7fff, 1'b0, 32'h0},
      '{ACT_BEAT, mme_pkg::KIND_LOAD_A,   3'd0, 3'd2, 16'h8000, 1'b0, 32'h0},
      '{ACT_BEAT, mme_pkg::KIND_LOAD_B,   3'd2, 3'd0, 16'h7fff, 1'b0, 32'h0},
      '{ACT_REG,  mme_pkg::CSR_INNER_DIM, 3'd0, 3'd0, 16'h0003, 1'b0, 32'h0},
      '{ACT_BEAT, mme_pkg::KIND_START,    3'd0, 3'd0, 16'h0000, 1'b1, 32'h8000_0000},
      '{ACT_REG,  mme_pkg::CSR_INNER_DIM, 3'd0, 3'd0, 16'h0000, 1'b0, 32'h0},
      '{ACT_BEAT, mme_pkg::KIND_START,    3'd0, 3'd0, 16'h0000, 1'b1, 32'hc000_8000},
      '{ACT_REG,  mme_pkg::CSR_ROWS_A,    3'd0, 3'd0, 16'h000f, 1'b0, 32'h0},
      '{ACT_REG,  mme_pkg::CSR_COLS_B,    3'd0, 3'd0, 16'h0000, 1'b0, 32'h0},
      '{ACT_BEAT, mme_pkg::KIND_LOAD_A,   3'd7, 3'd0, 16'h7fff, 1'b0, 32'h0},
      '{ACT_BEAT, mme_pkg::KIND_START,    3'd0, 3'd0, 16'h0000, 1'b0, 32'h0},
      '{ACT_REG,  mme_pkg::CSR_ROWS_A,    3'd0, 3'd0, 16'h0002, 1'b0, 32'h0},
      '{ACT_REG,  mme_pkg::CSR_INNER_DIM, 3'd0, 3'd0, 16'h0002, 1'b0, 32'h0},
      '{ACT_REG,  mme_pkg::CSR_COLS_B,    3'd0, 3'd0, 16'h0003, 1'b0, 32'h0},
      '{ACT_BEAT, mme_pkg::KIND_START,    3'd0, 3'd0, 16'h0000, 1'b0, 32'h0}
   };

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic [1:0]                        req_kind = '0;
   logic [mme_pkg::IDX_W-1:0]         req_elem_row = '0;
   logic [mme_pkg::IDX_W-1:0]         req_elem_col = '0;
   logic signed [mme_pkg::ELEM_W-1:0] req_elem_value = '0;
   logic                              rsp_strobe;
   logic signed [mme_pkg::ACC_W-1:0]  rsp_prod_value;
   logic [mme_pkg::IDX_W-1:0]         rsp_prod_row;
   logic [mme_pkg::IDX_W-1:0]         rsp_prod_col;
   logic                              rsp_last;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [mme_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [mme_pkg::DIM_W-1:0]         csr_data = '0;

   logic signed [mme_pkg::ELEM_W-1:0] left_mem  [STORE_DEPTH];
   logic signed [mme_pkg::ELEM_W-1:0] right_mem [STORE_DEPTH];
   bit                                left_set  [STORE_DEPTH];
   bit                                right_set [STORE_DEPTH];
   logic [mme_pkg::DIM_W-1:0]         shape_rows  = mme_pkg::DIM_RESET;
   logic [mme_pkg::DIM_W-1:0]         shape_inner = mme_pkg::DIM_RESET;
   logic [mme_pkg::DIM_W-1:0]         shape_cols  = mme_pkg::DIM_RESET;

   cell_type pending_cells [$];
   int       mismatches  = 0;
   int       beats_sent  = 0;
   int       quiet_count = 0;
   bit       burst       = 1'b0;

   matrix_multiply_engine i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_elem_row   (req_elem_row),
      .req_elem_col   (req_elem_col),
      .req_elem_value (req_elem_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_prod_value (rsp_prod_value),
      .rsp_prod_row   (rsp_prod_row),
      .rsp_prod_col   (rsp_prod_col),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int fit_dim(logic [mme_pkg::DIM_W-1:0] v);
      if (v == '0) return 1;
      if (v > mme_pkg::MAX_DIM_DEF) return mme_pkg::MAX_DIM_DEF;
      return int'(v);
   endfunction

   function automatic logic [mme_pkg::ELEM_W-1:0] pick_value();
      case ($urandom_range(0, 4))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(0, 511)) - 16'd256;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [mme_pkg::DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0: return 4'd0;
         1: return 4'd15;
         2: return 4'd8;
         3: return 4'($urandom_range(9, 14));
         default: return 4'($urandom_range(1, 3));
      endcase
   endfunction

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_reg(mme_pkg::csr_index_type idx, logic [mme_pkg::DIM_W-1:0] data);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         mme_pkg::CSR_ROWS_A:    shape_rows  = data;
         mme_pkg::CSR_INNER_DIM: shape_inner = data;
         mme_pkg::CSR_COLS_B:    shape_cols  = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // drives one beat, then updates the stores or expands the product on acceptance
   task automatic send_beat(logic [1:0] kind, logic [mme_pkg::IDX_W-1:0] row,
                            logic [mme_pkg::IDX_W-1:0] col,
                            logic [mme_pkg::ELEM_W-1:0] value, logic chk,
                            logic [mme_pkg::ACC_W-1:0] want);
      int       gap;
      int       nr, nk, nc;
      longint   acc;
      cell_type entry;
      gap = burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_kind       <= kind;
      req_elem_row   <= row;
      req_elem_col   <= col;
      req_elem_value <= value;
      do @(posedge clock); while (busy);
      if (kind != KIND_SPARE) beats_sent++;
      case (kind)
         mme_pkg::KIND_LOAD_A: begin
            left_mem[{row, col}] = value;
            left_set[{row, col}] = 1'b1;
         end
         mme_pkg::KIND_LOAD_B: begin
            right_mem[{row, col}] = value;
            right_set[{row, col}] = 1'b1;
         end
         mme_pkg::KIND_START: begin
            nr = fit_dim(shape_rows);
            nk = fit_dim(shape_inner);
            nc = fit_dim(shape_cols);
            for (int r = 0; r < nr; r++) begin
               for (int c = 0; c < nc; c++) begin
                  acc = 0;
                  for (int k = 0; k < nk; k++) begin
                     acc += longint'(left_mem[r*mme_pkg::MAX_DIM_DEF+k])
                          * longint'(right_mem[k*mme_pkg::MAX_DIM_DEF+c]);
                     if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                     if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                  end
                  entry.value = chk ? want : acc[mme_pkg::ACC_W-1:0];
                  entry.row   = mme_pkg::IDX_W'(r);
                  entry.col   = mme_pkg::IDX_W'(c);
                  entry.last  = (r == nr - 1) && (c == nc - 1);
                  pending_cells.push_back(entry);
               end
            end
         end
         default: ;
      endcase
   endtask

   // loads any element the product would read that was never written, then starts
   task automatic run_product(logic chk, logic [mme_pkg::ACC_W-1:0] want);
      int nr, nk, nc;
      nr = fit_dim(shape_rows);
      nk = fit_dim(shape_inner);
      nc = fit_dim(shape_cols);
      for (int r = 0; r < nr; r++)
         for (int k = 0; k < nk; k++)
            if (!left_set[r*mme_pkg::MAX_DIM_DEF+k])
               send_beat(mme_pkg::KIND_LOAD_A, mme_pkg::IDX_W'(r), mme_pkg::IDX_W'(k),
                         pick_value(), 1'b0, '0);
      for (int k = 0; k < nk; k++)
         for (int c = 0; c < nc; c++)
            if (!right_set[k*mme_pkg::MAX_DIM_DEF+c])
               send_beat(mme_pkg::KIND_LOAD_B, mme_pkg::IDX_W'(k), mme_pkg::IDX_W'(c),
                         pick_value(), 1'b0, '0);
      send_beat(mme_pkg::KIND_START, mme_pkg::IDX_W'($urandom), mme_pkg::IDX_W'($urandom),
                16'($urandom), chk, want);
   endtask

   always @(posedge clock) begin
      cell_type exp_cell;
      if (!reset && rsp_strobe) begin
         if (pending_cells.size() == 0) begin
            $error("result beat with nothing pending: row %0d col %0d value %0d",
                   rsp_prod_row, rsp_prod_col, rsp_prod_value);
            mismatches++;
         end else begin
            exp_cell = pending_cells.pop_front();
            if (rsp_prod_value !== exp_cell.value) begin
               $error("prod_value: expected %0d, got %0d", exp_cell.value, rsp_prod_value);
               mismatches++;
            end
            if (rsp_prod_row !== exp_cell.row) begin
               $error("prod_row: expected %0d, got %0d", exp_cell.row, rsp_prod_row);
               mismatches++;
            end
            if (rsp_prod_col !== exp_cell.col) begin
               $error("prod_col: expected %0d, got %0d", exp_cell.col, rsp_prod_col);
               mismatches++;
            end
            if (rsp_last !== exp_cell.last) begin
               $error("last: expected %0d, got %0d", exp_cell.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_count <= 0;
      end else if (quiet_count >= STALL_LIMIT) begin
         $display("FAIL matrix_multiply_engine");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   initial begin
      int                        nr, nk, nc;
      logic [1:0]                lk;
      logic [mme_pkg::IDX_W-1:0] lr, lc;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_LEN; i++) begin
         if (PLAN[i].act == ACT_REG)
            set_reg(mme_pkg::csr_index_type'(PLAN[i].code),
                    PLAN[i].value[mme_pkg::DIM_W-1:0]);
         else if (PLAN[i].code == mme_pkg::KIND_START)
            run_product(PLAN[i].chk, PLAN[i].want);
         else
            send_beat(PLAN[i].code, PLAN[i].row, PLAN[i].col, PLAN[i].value, 1'b0, '0);
      end

      while (beats_sent < ITEM_TARGET) begin
         set_reg(mme_pkg::CSR_ROWS_A, pick_dim());
         set_reg(mme_pkg::CSR_INNER_DIM, pick_dim());
         set_reg(mme_pkg::CSR_COLS_B, pick_dim());
         nr = fit_dim(shape_rows);
         nk = fit_dim(shape_inner);
         nc = fit_dim(shape_cols);
         burst = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(0, 8)) begin
               case ($urandom_range(0, 9))
                  0: send_beat(KIND_SPARE, mme_pkg::IDX_W'($urandom),
                               mme_pkg::IDX_W'($urandom), pick_value(), 1'b0, '0);
                  1: send_beat(2'($urandom_range(0, 1)), mme_pkg::IDX_W'($urandom),
                               mme_pkg::IDX_W'($urandom), pick_value(), 1'b0, '0);
                  default: begin
                     if ($urandom_range(0, 1) == 0) begin
                        lk = mme_pkg::KIND_LOAD_A;
                        lr = mme_pkg::IDX_W'($urandom_range(0, nr - 1));
                        lc = mme_pkg::IDX_W'($urandom_range(0, nk - 1));
                     end else begin
                        lk = mme_pkg::KIND_LOAD_B;
                        lr = mme_pkg::IDX_W'($urandom_range(0, nk - 1));
                        lc = mme_pkg::IDX_W'($urandom_range(0, nc - 1));
                     end
                     send_beat(lk, lr, lc, pick_value(), 1'b0, '0);
                  end
               endcase
            end
            if ($urandom_range(0, 4) == 0) wait_idle();
            run_product(1'b0, '0);
         end
      end

      wait_idle();
      if (mismatches == 0 && pending_cells.size() == 0) begin
         $display("PASS matrix_multiply_engine");
      end else begin
         $display("FAIL matrix_multiply_engine");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/mme_pkg.sv
src/mme_ctrl.sv
src/mme_datapath.sv
src/matrix_multiply_engine.sv
dv/matrix_multiply_engine_tb.sv
